FILE: rtl/core/rfd_pkg.sv
// Shared types and constants for the record frame deframer.
// Holds the channel word structs, section and status codes and the header layout.
// No dependencies; every other file in rtl/core imports it.
`default_nettype none

package rfd_pkg;

    // Frame layout
    localparam int HEADER_BYTES = 19;
    localparam int NONCE_BYTES  = 12;
    localparam int TAG_BYTES    = 16;
    localparam int MIN_FRAME    = HEADER_BYTES + NONCE_BYTES + TAG_BYTES;

    // Byte offsets inside the header
    localparam int OFF_VERSION  = 0;
    localparam int OFF_TYPE     = 1;
    localparam int OFF_ROLE     = 2;
    localparam int OFF_SEQ_LAST = 10;
    localparam int OFF_CT_LAST  = 14;
    localparam int OFF_TAG_LAST = 18;

    localparam logic [7:0] ROLE_CLIENT = 8'h01;
    localparam logic [7:0] ROLE_SERVER = 8'h02;

    localparam int OFFSET_W  = 32;
    localparam int OFF_INC_W = OFFSET_W + 1;
    localparam int SHORT_W   = $clog2(MIN_FRAME + 1);

    typedef enum logic [2:0] {
        SEC_HEADER = 3'd0,
        SEC_NONCE  = 3'd1,
        SEC_CT     = 3'd2,
        SEC_TAG    = 3'd3,
        SEC_EXCESS = 3'd4
    } sec_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_BAD_ROLE  = 3'd2,
        STATUS_BAD_VER   = 3'd3,
        STATUS_SEQ_EXH   = 3'd4,
        STATUS_BAD_TAG   = 3'd5,
        STATUS_LEN_MISMA = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        CFG_VERSION = 1'b0,
        CFG_MAX_SEQ = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  section;
        logic [7:0]  byte_out;
        logic        done_res;
        logic [2:0]  status;
        logic        header_ready;
        logic [7:0]  content_type;
        logic        role_server;
        logic [63:0] sequence_res;
        logic [31:0] ct_length;
        logic [31:0] tag_len;
    } out_item_t;

    // Per-frame state as it stands after the current byte has been taken.
    typedef struct packed {
        sec_t               sec;
        logic               excess;
        logic [SHORT_W-1:0] short_count;
        logic [7:0]         version;
        logic [7:0]         ctype;
        logic [7:0]         role;
        logic [63:0]        seq;
        logic [31:0]        ct_len;
        logic [31:0]        tag_len;
    } view_t;

endpackage

`default_nettype wire

FILE: rtl/core/record_frame_deframer.sv
// Record frame deframer: top level with input register, result register and settings.
// Instantiates rfd_track and rfd_check; depends on rfd_pkg.
//
// Usage: frame bytes enter on in_valid/in_data with in_stall as back-pressure; each
// accepted word carries one byte and a flag on the frame's final byte. For every byte
// one result word leaves on out_valid/out_data: the byte, its section (header, nonce,
// ciphertext, tag, beyond the declared length), the decoded header fields once all 19
// header bytes are in, and on the final byte the frame status.
// A byte accepted into the input register is offered as a result once it has moved into
// the result register. One byte per cycle is taken while the receiver does not stall,
// set by the combinational section and status update between the two registers.
// When the receiver stalls, the result register holds its word; one more byte is taken
// into the input register, after which in_stall rises until the result is taken.
// Reset clears the valid flags of both registers and the frame state, sets
// expected_version to 1 and max_sequence to all ones. Settings are written through
// cfg_we/cfg_index/cfg_wdata and should only change while no frame byte is in flight.
`default_nettype none

module record_frame_deframer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rfd_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rfd_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire rfd_pkg::cfg_idx_t cfg_index,
    input  wire logic [63:0]       cfg_wdata
);
    import rfd_pkg::*;

    logic [7:0]  expected_version_reg;
    logic [63:0] max_sequence_reg;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    logic        s2_free;
    logic        s1_move;
    logic        in_take;
    sec_t        cur_sec;
    view_t       view;
    status_t     status;
    logic        ready;

    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    rfd_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_move),
        .item  (s1_item_reg),
        .sec   (cur_sec),
        .view  (view)
    );

    rfd_check u_check (
        .view             (view),
        .last             (s1_item_reg.last),
        .expected_version (expected_version_reg),
        .max_sequence     (max_sequence_reg),
        .status           (status)
    );

    // Header fields read as zero until the whole header is in.
    always_comb
    begin
        ready                        = (view.sec != SEC_HEADER);
        out_item_next.section        = cur_sec;
        out_item_next.byte_out       = s1_item_reg.data;
        out_item_next.done_res       = s1_item_reg.last;
        out_item_next.status         = status;
        out_item_next.header_ready   = ready;
        out_item_next.content_type   = ready ? view.ctype : '0;
        out_item_next.role_server    = ready && (view.role == ROLE_SERVER);
        out_item_next.sequence_res   = ready ? view.seq : '0;
        out_item_next.ct_length      = ready ? view.ct_len : '0;
        out_item_next.tag_len        = ready ? view.tag_len : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_version_reg <= 8'h01;
            max_sequence_reg     <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERSION: expected_version_reg <= cfg_wdata[7:0];
                CFG_MAX_SEQ: max_sequence_reg     <= cfg_wdata;
                default:     max_sequence_reg     <= max_sequence_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (s1_move)
            out_item_reg <= out_item_next;
    end

    a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.done_res |-> out_item_reg.status == STATUS_OK)
        else $error("status reported on a byte that does not end the frame");

    a_fields_zero_before_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.header_ready |->
            out_item_reg.content_type == '0 && out_item_reg.sequence_res == '0 &&
            out_item_reg.ct_length == '0 && out_item_reg.tag_len == '0 &&
            !out_item_reg.role_server)
        else $error("header fields shown before the header is complete");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while a register stage is free");

    a_excess_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.section == SEC_EXCESS |-> out_item_reg.header_ready)
        else $error("byte beyond the declared length before the header was complete");

endmodule

`default_nettype wire

FILE: rtl/core/rfd_track.sv
// Section tracker and header capture for the record frame deframer.
// Holds the per-frame state and works out its value after each byte.
// Depends on rfd_pkg.
`default_nettype none

module rfd_track (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire rfd_pkg::in_item_t item,
    output rfd_pkg::sec_t         sec,
    output rfd_pkg::view_t        view
);
    import rfd_pkg::*;

    sec_t                sec_reg,     sec_next;
    logic [OFFSET_W-1:0] off_reg,     off_next;
    logic [SHORT_W-1:0]  short_reg,   short_next;
    logic                excess_reg,  excess_next;
    logic [7:0]          version_reg, version_next;
    logic [7:0]          type_reg,    type_next;
    logic [7:0]          role_reg,    role_next;
    logic [63:0]         seq_reg,     seq_next;
    logic [31:0]         ct_len_reg,  ct_len_next;
    logic [31:0]         tag_len_reg, tag_len_next;
    logic [OFF_INC_W-1:0] off_inc;

    // Header capture
    always_comb
    begin
        version_next = version_reg;
        type_next    = type_reg;
        role_next    = role_reg;
        seq_next     = seq_reg;
        ct_len_next  = ct_len_reg;
        tag_len_next = tag_len_reg;
        if (sec_reg == SEC_HEADER)
        begin
            priority if (off_reg == OFFSET_W'(OFF_VERSION))
                version_next = item.data;
            else if (off_reg == OFFSET_W'(OFF_TYPE))
                type_next = item.data;
            else if (off_reg == OFFSET_W'(OFF_ROLE))
                role_next = item.data;
            else if (off_reg <= OFFSET_W'(OFF_SEQ_LAST))
                seq_next = {seq_reg[55:0], item.data};
            else if (off_reg <= OFFSET_W'(OFF_CT_LAST))
                ct_len_next = {ct_len_reg[23:0], item.data};
            else if (off_reg <= OFFSET_W'(OFF_TAG_LAST))
                tag_len_next = {tag_len_reg[23:0], item.data};
        end
    end

    // Section advance; empty ciphertext or tag sections are passed over at once.
    always_comb
    begin
        off_inc     = {1'b0, off_reg} + OFF_INC_W'(1);
        off_next    = off_inc[OFFSET_W-1:0];
        sec_next    = sec_reg;
        excess_next = excess_reg;
        short_next  = (short_reg < SHORT_W'(MIN_FRAME)) ? short_reg + SHORT_W'(1) : short_reg;
        unique case (sec_reg)
            SEC_HEADER:
            begin
                if (off_inc >= OFF_INC_W'(HEADER_BYTES))
                begin
                    sec_next = SEC_NONCE;
                    off_next = '0;
                end
            end
            SEC_NONCE:
            begin
                if (off_inc >= OFF_INC_W'(NONCE_BYTES))
                begin
                    off_next = '0;
                    if (ct_len_reg != '0)
                        sec_next = SEC_CT;
                    else if (tag_len_reg != '0)
                        sec_next = SEC_TAG;
                    else
                        sec_next = SEC_EXCESS;
                end
            end
            SEC_CT:
            begin
                if (off_inc >= {1'b0, ct_len_reg})
                begin
                    off_next = '0;
                    sec_next = (tag_len_reg != '0) ? SEC_TAG : SEC_EXCESS;
                end
            end
            SEC_TAG:
            begin
                if (off_inc >= {1'b0, tag_len_reg})
                begin
                    off_next = '0;
                    sec_next = SEC_EXCESS;
                end
            end
            SEC_EXCESS:
            begin
                excess_next = 1'b1;
                off_next    = '0;
            end
            default:
            begin
                sec_next = SEC_HEADER;
                off_next = '0;
            end
        endcase
    end

    always_comb
    begin
        sec              = sec_reg;
        view.sec         = sec_next;
        view.excess      = excess_next;
        view.short_count = short_next;
        view.version     = version_next;
        view.ctype       = type_next;
        view.role        = role_next;
        view.seq         = seq_next;
        view.ct_len      = ct_len_next;
        view.tag_len     = tag_len_next;
    end

    // The final byte of a frame returns everything to the start of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg     <= SEC_HEADER;
            off_reg     <= '0;
            short_reg   <= '0;
            excess_reg  <= 1'b0;
            version_reg <= '0;
            type_reg    <= '0;
            role_reg    <= '0;
            seq_reg     <= '0;
            ct_len_reg  <= '0;
            tag_len_reg <= '0;
        end
        else if (en)
        begin
            if (item.last)
            begin
                sec_reg     <= SEC_HEADER;
                off_reg     <= '0;
                short_reg   <= '0;
                excess_reg  <= 1'b0;
                version_reg <= '0;
                type_reg    <= '0;
                role_reg    <= '0;
                seq_reg     <= '0;
                ct_len_reg  <= '0;
                tag_len_reg <= '0;
            end
            else
            begin
                sec_reg     <= sec_next;
                off_reg     <= off_next;
                short_reg   <= short_next;
                excess_reg  <= excess_next;
                version_reg <= version_next;
                type_reg    <= type_next;
                role_reg    <= role_next;
                seq_reg     <= seq_next;
                ct_len_reg  <= ct_len_next;
                tag_len_reg <= tag_len_next;
            end
        end
    end

    a_excess_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg == SEC_EXCESS |-> off_reg == '0)
        else $error("offset not zero beyond the declared length");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        en && item.last |=> sec_reg == SEC_HEADER && off_reg == '0 && short_reg == '0)
        else $error("frame state not cleared after the final byte");

    a_ct_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg == SEC_CT |-> off_reg < ct_len_reg)
        else $error("ciphertext offset has run past its length");

endmodule

`default_nettype wire

FILE: rtl/core/rfd_check.sv
// Frame status check for the record frame deframer.
// Picks the first failing check on the final byte of a frame.
// Depends on rfd_pkg.
`default_nettype none

module rfd_check (
    input  wire rfd_pkg::view_t view,
    input  wire logic           last,
    input  wire logic [7:0]     expected_version,
    input  wire logic [63:0]    max_sequence,
    output rfd_pkg::status_t    status
);
    import rfd_pkg::*;

    always_comb
    begin
        status = STATUS_OK;
        if (last)
        begin
            priority if (view.short_count < SHORT_W'(MIN_FRAME))
                status = STATUS_SHORT;
            else if (view.role != ROLE_CLIENT && view.role != ROLE_SERVER)
                status = STATUS_BAD_ROLE;
            else if (view.version != expected_version)
                status = STATUS_BAD_VER;
            else if (view.seq > max_sequence)
                status = STATUS_SEQ_EXH;
            else if (view.tag_len != 32'(TAG_BYTES))
                status = STATUS_BAD_TAG;
            else if (view.sec != SEC_EXCESS || view.excess)
                status = STATUS_LEN_MISMA;
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for record_frame_deframer: sends whole frames a byte at a time and
// checks every result word against a predictor of the section, header and status logic.
// Depends on rfd_pkg and the RTL in rtl/core only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    localparam int CYCLE_LIMIT       = 100000;
    localparam int DRAIN_CYCLES      = 4;
    localparam int BYTES_PER_PHASE   = 20;
    localparam int REPORT_MISMATCHES = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_wdata;

    record_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor copy of the frame state and the settings.
    sec_t            cur_sec;
    longint unsigned sec_offset;
    int unsigned     short_cnt;
    logic [7:0]      hdr_version;
    logic [7:0]      hdr_type;
    logic [7:0]      hdr_role;
    logic [63:0]     hdr_seq;
    logic [31:0]     hdr_ct_len;
    logic [31:0]     hdr_tag_len;
    bit              past_end;
    logic [7:0]      want_version;
    logic [63:0]     max_seq_cfg;

    out_item_t   expected_words[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned frames_sent;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    int unsigned status_count[7];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_frame_state();
        cur_sec     = SEC_HEADER;
        sec_offset  = 0;
        short_cnt   = 0;
        hdr_version = '0;
        hdr_type    = '0;
        hdr_role    = '0;
        hdr_seq     = '0;
        hdr_ct_len  = '0;
        hdr_tag_len = '0;
        past_end    = 1'b0;
    endfunction

    // Works out the result word for one accepted byte and moves the frame state on.
    function automatic out_item_t predict_deframe(input logic [7:0] b, input logic is_last);
        sec_t      sec_in;
        status_t   st;
        logic      ready;
        out_item_t w;
        sec_in = cur_sec;
        st     = STATUS_OK;
        if (sec_in == SEC_HEADER)
        begin
            if (sec_offset == OFF_VERSION)
                hdr_version = b;
            else if (sec_offset == OFF_TYPE)
                hdr_type = b;
            else if (sec_offset == OFF_ROLE)
                hdr_role = b;
            else if (sec_offset <= OFF_SEQ_LAST)
                hdr_seq = {hdr_seq[55:0], b};
            else if (sec_offset <= OFF_CT_LAST)
                hdr_ct_len = {hdr_ct_len[23:0], b};
            else
                hdr_tag_len = {hdr_tag_len[23:0], b};
        end
        if (short_cnt < MIN_FRAME)
            short_cnt++;
        // Empty sections are passed over in the same step.
        if (sec_in == SEC_EXCESS)
        begin
            past_end   = 1'b1;
            sec_offset = 0;
        end
        else
        begin
            sec_offset++;
            if (cur_sec == SEC_HEADER && sec_offset >= HEADER_BYTES)
            begin
                cur_sec    = SEC_NONCE;
                sec_offset = 0;
            end
            if (cur_sec == SEC_NONCE && sec_offset >= NONCE_BYTES)
            begin
                cur_sec    = SEC_CT;
                sec_offset = 0;
            end
            if (cur_sec == SEC_CT && sec_offset >= 64'(hdr_ct_len))
            begin
                cur_sec    = SEC_TAG;
                sec_offset = 0;
            end
            if (cur_sec == SEC_TAG && sec_offset >= 64'(hdr_tag_len))
            begin
                cur_sec    = SEC_EXCESS;
                sec_offset = 0;
            end
        end
        ready = (cur_sec != SEC_HEADER);
        if (is_last)
        begin
            if (short_cnt < MIN_FRAME)
                st = STATUS_SHORT;
            else if (hdr_role != ROLE_CLIENT && hdr_role != ROLE_SERVER)
                st = STATUS_BAD_ROLE;
            else if (hdr_version != want_version)
                st = STATUS_BAD_VER;
            else if (hdr_seq > max_seq_cfg)
                st = STATUS_SEQ_EXH;
            else if (hdr_tag_len != TAG_BYTES)
                st = STATUS_BAD_TAG;
            else if (cur_sec != SEC_EXCESS || past_end)
                st = STATUS_LEN_MISMA;
        end
        w.section        = sec_in;
        w.byte_out       = b;
        w.done_res       = is_last;
        w.status         = st;
        w.header_ready   = ready;
        w.content_type   = ready ? hdr_type : 8'd0;
        w.role_server    = ready && hdr_role == ROLE_SERVER;
        w.sequence_res   = ready ? hdr_seq : 64'd0;
        w.ct_length      = ready ? hdr_ct_len : 32'd0;
        w.tag_len        = ready ? hdr_tag_len : 32'd0;
        if (is_last)
            clear_frame_state();
        return w;
    endfunction

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MISMATCHES)
                $display("Mismatch in %s of result word %0d: expected %0h, got %0h",
                         name, results_checked, want, got);
        end
    endtask

    // Results are checked before the new byte is predicted, so an early word cannot hide.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MISMATCHES)
                        $display("Result word %0h arrived with nothing expected", out_data);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("section", out_data.section, want.section);
                    check_field("byte_out", out_data.byte_out, want.byte_out);
                    check_field("done_res", out_data.done_res, want.done_res);
                    check_field("status", out_data.status, want.status);
                    check_field("header_ready", out_data.header_ready, want.header_ready);
                    check_field("content_type", out_data.content_type, want.content_type);
                    check_field("role_server", out_data.role_server, want.role_server);
                    check_field("sequence_res", out_data.sequence_res, want.sequence_res);
                    check_field("ct_length", out_data.ct_length, want.ct_length);
                    check_field("tag_len", out_data.tag_len, want.tag_len);
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                want = predict_deframe(in_data.data, in_data.last);
                expected_words = {expected_words, want};
                if (want.done_res)
                    status_count[want.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Gave up after %0d cycles with %0d result words outstanding.",
                     cycle_count, expected_words.size());
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    // Returns at a falling edge with valid still high, so back-to-back words need no gap.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, is_last};
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] ver, ctype, role, input logic [63:0] seq_num,
                              input logic [31:0] ct_len, tag_len, input int unsigned total);
        logic [151:0] hdr;
        logic [7:0]   b;
        hdr = {ver, ctype, role, seq_num, ct_len, tag_len};
        for (int unsigned i = 0; i < total; i++)
        begin
            b = (i < HEADER_BYTES) ? hdr[151 - 8 * i -: 8] : 8'($urandom);
            send_byte(b, i == total - 1);
        end
        frames_sent++;
    endtask

    task automatic write_setting(input cfg_idx_t idx, input logic [63:0] value);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VERSION)
            want_version = value[7:0];
        else
            max_seq_cfg = value;
    endtask

    // Mostly well-formed frames with random content; the rest break one rule or several.
    task automatic send_random_frame();
        logic [7:0]  ver;
        logic [7:0]  ctype;
        logic [7:0]  role;
        logic [63:0] seq_num;
        logic [31:0] ct_len;
        logic [31:0] tag_len;
        int unsigned total;
        ver     = want_version;
        ctype   = 8'($urandom);
        role    = $urandom_range(0, 1) ? ROLE_SERVER : ROLE_CLIENT;
        seq_num = {$urandom, $urandom};
        if (max_seq_cfg != '1)
            seq_num = seq_num % (max_seq_cfg + 64'd1);
        ct_len  = $urandom_range(0, 12);
        tag_len = TAG_BYTES;
        total   = HEADER_BYTES + NONCE_BYTES + ct_len + tag_len;
        case ($urandom_range(0, 19))
            13: total = $urandom_range(1, MIN_FRAME - 1);
            14: role = 8'($urandom);
            15: ver = 8'($urandom);
            16: if (max_seq_cfg != '1) seq_num = max_seq_cfg + 64'd1;
            17:
            begin
                tag_len = $urandom_range(0, 40);
                total   = HEADER_BYTES + NONCE_BYTES + ct_len + tag_len;
            end
            18:
            begin
                if ($urandom_range(0, 1))
                    total = total + $urandom_range(1, 4);
                else
                    total = total - $urandom_range(1, 10);
            end
            19:
            begin
                ver     = 8'($urandom);
                role    = 8'($urandom);
                ct_len  = $urandom;
                tag_len = $urandom;
                total   = $urandom_range(1, 90);
            end
            default: ;
        endcase
        send_frame(ver, ctype, role, seq_num, ct_len, tag_len, total);
    endtask

    task automatic test_well_formed();
        send_frame(8'd1, 8'hFF, ROLE_SERVER, '1, 32'd3, TAG_BYTES, MIN_FRAME + 3);
    endtask

    task automatic test_short_frames();
        send_frame(8'd1, 8'h17, ROLE_CLIENT, 64'd1, 32'd0, TAG_BYTES, 1);
        send_frame(8'd1, 8'h17, ROLE_SERVER, 64'd2, 32'd0, TAG_BYTES, HEADER_BYTES);
    endtask

    task automatic test_header_checks();
        // A bad role outranks a bad version.
        send_frame(8'd2, 8'h20, 8'hFF, 64'd4, 32'd0, TAG_BYTES, MIN_FRAME);
        send_frame(8'd2, 8'h21, ROLE_CLIENT, 64'd5, 32'd0, TAG_BYTES, MIN_FRAME);
        send_frame(8'd1, 8'h22, ROLE_SERVER, 64'd6, 32'd4, 32'd15, MIN_FRAME + 3);
    endtask

    task automatic test_sequence_limit();
        write_setting(CFG_MAX_SEQ, 64'd5);
        send_frame(8'd1, 8'h30, ROLE_CLIENT, 64'd6, 32'd0, TAG_BYTES, MIN_FRAME);
        write_setting(CFG_MAX_SEQ, '1);
    endtask

    task automatic test_length_mismatch();
        send_frame(8'd1, 8'h40, ROLE_CLIENT, 64'd10, 32'd0, TAG_BYTES, MIN_FRAME + 3);
    endtask

    task automatic test_random_frames(input int unsigned send_pct, recv_pct,
                                      input logic [7:0] ver, input logic [63:0] max_seq);
        int unsigned start_bytes;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_setting(CFG_VERSION, 64'(ver));
        write_setting(CFG_MAX_SEQ, max_seq);
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < BYTES_PER_PHASE)
            send_random_frame();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_VERSION;
        cfg_wdata      = '0;
        want_version   = 8'd1;
        max_seq_cfg    = '1;
        send_idle_pct  = 6;
        recv_stall_pct = 51;
        clear_frame_state();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_well_formed();
        test_short_frames();
        test_header_checks();
        test_sequence_limit();
        test_length_mismatch();
        test_random_frames(6, 51, 8'd1, '1);
        test_random_frames(51, 6, 8'($urandom), {$urandom, $urandom});
        test_random_frames(0, 0, 8'd255, 64'd0);

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d frames (%0d bytes) and checked %0d result words.",
                 frames_sent, bytes_sent, results_checked);
        $display("Frame outcomes: ok %0d, short %0d, bad role %0d, bad version %0d,",
                 status_count[STATUS_OK], status_count[STATUS_SHORT],
                 status_count[STATUS_BAD_ROLE], status_count[STATUS_BAD_VER]);
        $display("  sequence spent %0d, bad tag %0d, length mismatch %0d.",
                 status_count[STATUS_SEQ_EXH], status_count[STATUS_BAD_TAG],
                 status_count[STATUS_LEN_MISMA]);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: record_frame_deframer.f
rtl/core/rfd_pkg.sv
rtl/core/rfd_track.sv
rtl/core/rfd_check.sv
rtl/core/record_frame_deframer.sv
tb/testbench.sv
